/* rtl/clipped_window_command_gen_macros.svh */
// Assertion macros for the clipped window command generator checker.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef CLIPPED_WINDOW_COMMAND_GEN_MACROS_SVH
`define CLIPPED_WINDOW_COMMAND_GEN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CWCG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CWCG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cwcg_pkg.sv */
// Shared types, constants and the byte selection function of the
// clipped window command generator. No dependencies.
package cwcg_pkg;

    localparam int COORD_W    = 18;  // signed working width for edges
    localparam int DIM_W      = 13;  // clipped width/height, up to 8191
    localparam int POS_W      = 16;  // start/end coordinate sent to the panel
    localparam int STRIDE_W   = 16;
    localparam int SKIP_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int OFFSET_W   = 32;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 4;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 64;

    localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2a;
    localparam logic [BYTE_W-1:0] CMD_ROW    = 8'h2b;
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2c;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_WIDTH  = 2'd2,
        REG_CLIP_HEIGHT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [8:0] left;
        logic [7:0] top;
        logic [8:0] width;
        logic [7:0] height;
    } cfg_t;

    // Clipped geometry after the compare stages.
    typedef struct packed {
        logic                visible;
        logic [POS_W-1:0]    x0;
        logic [POS_W-1:0]    x1;
        logic [POS_W-1:0]    y0;
        logic [POS_W-1:0]    y1;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [SKIP_W-1:0]   skip_rows;
        logic [SKIP_W-1:0]   skip_cols;
        logic [STRIDE_W-1:0] stride;
    } geom_t;

    // Everything the serializer needs for one request.
    typedef struct packed {
        logic                visible;
        logic [POS_W-1:0]    x0;
        logic [POS_W-1:0]    x1;
        logic [POS_W-1:0]    y0;
        logic [POS_W-1:0]    y1;
        logic [COUNT_W-1:0]  count;
        logic [OFFSET_W-1:0] offset;
        logic                contig;
    } record_t;

    typedef enum logic [3:0] {
        SEQ_CMD_COL = 4'd0,
        SEQ_X0_HI   = 4'd1,
        SEQ_X0_LO   = 4'd2,
        SEQ_X1_HI   = 4'd3,
        SEQ_X1_LO   = 4'd4,
        SEQ_CMD_ROW = 4'd5,
        SEQ_Y0_HI   = 4'd6,
        SEQ_Y0_LO   = 4'd7,
        SEQ_Y1_HI   = 4'd8,
        SEQ_Y1_LO   = 4'd9,
        SEQ_CMD_WR  = 4'd10
    } seq_t;

    function automatic logic [BYTE_W-1:0] seq_byte(seq_t s, record_t r);
        logic [BYTE_W-1:0] b;
        unique case (s)
            SEQ_CMD_COL: b = CMD_COLUMN;
            SEQ_X0_HI:   b = r.x0[15:8];
            SEQ_X0_LO:   b = r.x0[7:0];
            SEQ_X1_HI:   b = r.x1[15:8];
            SEQ_X1_LO:   b = r.x1[7:0];
            SEQ_CMD_ROW: b = CMD_ROW;
            SEQ_Y0_HI:   b = r.y0[15:8];
            SEQ_Y0_LO:   b = r.y0[7:0];
            SEQ_Y1_HI:   b = r.y1[15:8];
            SEQ_Y1_LO:   b = r.y1[7:0];
            SEQ_CMD_WR:  b = CMD_WRITE;
            default:     b = '0;
        endcase
        return b;
    endfunction

    function automatic logic seq_is_cmd(seq_t s);
        return (s == SEQ_CMD_COL) || (s == SEQ_CMD_ROW) || (s == SEQ_CMD_WR);
    endfunction

endpackage

/* rtl/cwcg_regs.sv */
// Clip area registers behind an APB-style write/read port.
// Depends on cwcg_pkg.
module cwcg_regs #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwcg_pkg::ADDR_W-1:0]        paddr,
    input  logic [cwcg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cwcg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output cwcg_pkg::cfg_t                     cfg
);
    import cwcg_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_CLIP_LEFT:   cfg_next.left   = pwdata[8:0];
                REG_CLIP_TOP:    cfg_next.top    = pwdata[7:0];
                REG_CLIP_WIDTH:  cfg_next.width  = pwdata[8:0];
                REG_CLIP_HEIGHT: cfg_next.height = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CLIP_LEFT:   prdata = APB_DATA_W'(cfg_reg.left);
            REG_CLIP_TOP:    prdata = APB_DATA_W'(cfg_reg.top);
            REG_CLIP_WIDTH:  prdata = APB_DATA_W'(cfg_reg.width);
            REG_CLIP_HEIGHT: prdata = APB_DATA_W'(cfg_reg.height);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left   <= '0;
            cfg_reg.top    <= '0;
            cfg_reg.width  <= 9'(SCREEN_WIDTH);
            cfg_reg.height <= 8'(SCREEN_HEIGHT);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/cwcg_clip.sv */
// Three-stage clip pipeline: edges, intersection, emptiness and extents.
// Depends on cwcg_pkg.
module cwcg_clip #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cwcg_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [15:0]               draw_x,
    input  logic signed [15:0]               draw_y,
    input  logic [14:0]                      draw_width,
    input  logic [14:0]                      draw_height,
    input  logic [cwcg_pkg::STRIDE_W-1:0]    row_stride,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cwcg_pkg::geom_t                  out_geom
);
    import cwcg_pkg::*;

    // stage 1: draw edges and on-screen clip edges
    logic                s1_valid_reg;
    coord_t              dx1_reg, dy1_reg, dr1_reg, db1_reg;
    coord_t              cl1_reg, ct1_reg, cr1_reg, cb1_reg;
    logic [STRIDE_W-1:0] stride1_reg;
    // stage 2: intersection
    logic                s2_valid_reg;
    coord_t              dx2_reg, dy2_reg, nx2_reg, ny2_reg, nr2_reg, nb2_reg;
    logic [STRIDE_W-1:0] stride2_reg;
    // stage 3: emptiness and extents
    logic                s3_valid_reg;
    geom_t               geom3_reg, geom3_next;

    logic   s1_adv, s2_adv, s3_adv;
    coord_t dx_in, dy_in, dr_in, db_in, cl_in, ct_in, cr_raw, cb_raw, cr_in, cb_in;
    coord_t sw_c, sh_c;
    coord_t w_full, h_full, x1_full, y1_full, srow_full, scol_full;

    assign s3_adv   = !s3_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    assign sw_c   = coord_t'(SCREEN_WIDTH);
    assign sh_c   = coord_t'(SCREEN_HEIGHT);
    assign dx_in  = coord_t'(draw_x);
    assign dy_in  = coord_t'(draw_y);
    assign dr_in  = dx_in + coord_t'(COORD_W'(draw_width));
    assign db_in  = dy_in + coord_t'(COORD_W'(draw_height));
    assign cl_in  = coord_t'(COORD_W'(cfg.left));
    assign ct_in  = coord_t'(COORD_W'(cfg.top));
    assign cr_raw = cl_in + coord_t'(COORD_W'(cfg.width));
    assign cb_raw = ct_in + coord_t'(COORD_W'(cfg.height));
    assign cr_in  = (cr_raw > sw_c) ? sw_c : cr_raw;
    assign cb_in  = (cb_raw > sh_c) ? sh_c : cb_raw;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            dx1_reg     <= dx_in;
            dy1_reg     <= dy_in;
            dr1_reg     <= dr_in;
            db1_reg     <= db_in;
            cl1_reg     <= cl_in;
            ct1_reg     <= ct_in;
            cr1_reg     <= cr_in;
            cb1_reg     <= cb_in;
            stride1_reg <= row_stride;
        end
        if (s2_adv) begin
            dx2_reg     <= dx1_reg;
            dy2_reg     <= dy1_reg;
            nx2_reg     <= (dx1_reg < cl1_reg) ? cl1_reg : dx1_reg;
            ny2_reg     <= (dy1_reg < ct1_reg) ? ct1_reg : dy1_reg;
            nr2_reg     <= (dr1_reg > cr1_reg) ? cr1_reg : dr1_reg;
            nb2_reg     <= (db1_reg > cb1_reg) ? cb1_reg : db1_reg;
            stride2_reg <= stride1_reg;
        end
        if (s3_adv) begin
            geom3_reg <= geom3_next;
        end
    end

    // End coordinates are the exclusive edges minus one.
    assign w_full    = nr2_reg - nx2_reg;
    assign h_full    = nb2_reg - ny2_reg;
    assign x1_full   = nr2_reg - coord_t'(1);
    assign y1_full   = nb2_reg - coord_t'(1);
    assign srow_full = ny2_reg - dy2_reg;
    assign scol_full = nx2_reg - dx2_reg;

    always_comb begin
        geom3_next.visible   = (nr2_reg > nx2_reg) && (nb2_reg > ny2_reg);
        geom3_next.x0        = nx2_reg[POS_W-1:0];
        geom3_next.x1        = x1_full[POS_W-1:0];
        geom3_next.y0        = ny2_reg[POS_W-1:0];
        geom3_next.y1        = y1_full[POS_W-1:0];
        geom3_next.w         = w_full[DIM_W-1:0];
        geom3_next.h         = h_full[DIM_W-1:0];
        geom3_next.skip_rows = srow_full[SKIP_W-1:0];
        geom3_next.skip_cols = scol_full[SKIP_W-1:0];
        geom3_next.stride    = stride2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
            if (s3_adv) s3_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_geom  = geom3_reg;

endmodule

/* rtl/cwcg_math.sv */
// Two-stage product pipeline: pixel count, row offset product, then
// the final source offset. Depends on cwcg_pkg.
module cwcg_math (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cwcg_pkg::geom_t      in_geom,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cwcg_pkg::record_t    out_rec
);
    import cwcg_pkg::*;

    logic                s4_valid_reg, s5_valid_reg;
    logic                s4_adv, s5_adv;
    logic                vis4_reg, contig4_reg;
    logic [POS_W-1:0]    x04_reg, x14_reg, y04_reg, y14_reg;
    logic [COUNT_W-1:0]  count4_reg;
    logic [OFFSET_W-1:0] prod4_reg;
    logic [SKIP_W-1:0]   scol4_reg;
    logic [2*DIM_W-1:0]  area;
    record_t             rec5_reg, rec5_next;

    assign s5_adv   = !s5_valid_reg || out_ready;
    assign s4_adv   = !s4_valid_reg || s5_adv;
    assign in_ready = s4_adv;

    assign area = in_geom.w * in_geom.h;

    always_ff @(posedge aclk) begin
        if (s4_adv) begin
            vis4_reg    <= in_geom.visible;
            x04_reg     <= in_geom.x0;
            x14_reg     <= in_geom.x1;
            y04_reg     <= in_geom.y0;
            y14_reg     <= in_geom.y1;
            count4_reg  <= area[COUNT_W-1:0];
            prod4_reg   <= in_geom.skip_rows * in_geom.stride;
            scol4_reg   <= in_geom.skip_cols;
            contig4_reg <= (STRIDE_W'(in_geom.w) == in_geom.stride);
        end
        if (s5_adv) begin
            rec5_reg <= rec5_next;
        end
    end

    always_comb begin
        rec5_next.visible = vis4_reg;
        rec5_next.x0      = x04_reg;
        rec5_next.x1      = x14_reg;
        rec5_next.y0      = y04_reg;
        rec5_next.y1      = y14_reg;
        rec5_next.count   = count4_reg;
        rec5_next.offset  = prod4_reg + OFFSET_W'(scol4_reg);
        rec5_next.contig  = contig4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s4_adv) s4_valid_reg <= in_valid;
            if (s5_adv) s5_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_rec   = rec5_reg;

endmodule

/* rtl/cwcg_serial.sv */
// Serializer: holds one request record and walks the window command
// sequence into a registered output channel. Depends on cwcg_pkg.
module cwcg_serial (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cwcg_pkg::record_t                   in_rec,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cwcg_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);
    import cwcg_pkg::*;

    logic                 rec_valid_reg, rec_valid_next;
    record_t              rec_reg;
    seq_t                 idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] tdata_reg, tdata_next;
    logic                 tlast_reg, tlast_next;
    logic                 tuser_reg, tuser_next;
    logic                 out_load, final_word, rec_load;
    logic [BYTE_W-1:0]    byte_sel;

    assign out_load   = rec_valid_reg && (!out_valid_reg || m_tready);
    assign final_word = !rec_reg.visible || (idx_reg == SEQ_CMD_WR);
    assign in_ready   = !rec_valid_reg || (out_load && final_word);
    assign rec_load   = in_valid && in_ready;
    assign byte_sel   = seq_byte(idx_reg, rec_reg);

    always_comb begin
        rec_valid_next = rec_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        tdata_next     = tdata_reg;
        tlast_next     = tlast_reg;
        tuser_next     = tuser_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            tlast_next     = final_word;
            tdata_next     = '0;
            tuser_next     = 1'b0;
            if (rec_reg.visible) begin
                tdata_next[0]   = 1'b1;
                tdata_next[8:1] = byte_sel;
                tuser_next      = seq_is_cmd(idx_reg);
                // totals ride on the closing word only
                if (final_word) begin
                    tdata_next[25:9]  = rec_reg.count;
                    tdata_next[57:26] = rec_reg.offset;
                    tdata_next[58]    = rec_reg.contig;
                end
            end
            if (final_word) begin
                rec_valid_next = 1'b0;
                idx_next       = SEQ_CMD_COL;
            end else begin
                idx_next = seq_t'(4'(idx_reg) + 4'd1);
            end
        end
        if (rec_load) begin
            rec_valid_next = 1'b1;
            idx_next       = SEQ_CMD_COL;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_load) begin
            rec_reg <= in_rec;
        end
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
        tuser_reg <= tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
            idx_reg       <= SEQ_CMD_COL;
            out_valid_reg <= 1'b0;
        end else begin
            rec_valid_reg <= rec_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

/* rtl/clipped_window_command_gen.sv */
// Top level of the clipped window command generator.
// Depends on cwcg_pkg, cwcg_regs, cwcg_clip, cwcg_math and cwcg_serial.
//
// A request word on the s_ channel carries a signed draw rectangle and a
// source row stride. The rectangle is clipped against the clip area held
// in four APB registers (left, top, width, height at byte addresses 0, 4,
// 8, 12); the area is limited to the screen before clipping.
// For a visible result the m_ channel carries eleven words: column command,
// start/end column bytes, row command, start/end row bytes, write command.
// m_tuser marks command words, m_tlast marks the write command, which also
// carries pixel count, source offset and the contiguous flag. An empty
// intersection gives one word with visible low and m_tlast high.
// The first word reaches the output register through the five pipeline
// stages and the serializer record. The serializer emits one word per
// cycle unless m_tready stalls it, and the pipeline keeps accepting up to
// five requests behind it. A stall on m_tready holds the output word and
// backs up the pipeline without loss. Reset clears all valid bits and loads
// the clip area with the full screen; no clearing pass is needed.
module clipped_window_command_gen #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwcg_pkg::ADDR_W-1:0]        paddr,
    input  logic [cwcg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cwcg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // draw_x[15:0], draw_y[31:16], draw_width[46:32], draw_height[61:47],
    // row_stride[77:62], zero fill [79:78]
    input  logic [cwcg_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // visible[0], out_byte[8:1], pixel_count[25:9], source_offset[57:26],
    // contiguous[58], zero fill [63:59]
    output logic [cwcg_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // is_command[0]
    output logic                               m_tuser
);
    import cwcg_pkg::*;

    cfg_t    cfg;
    logic    geom_valid, geom_ready, rec_valid, rec_ready;
    geom_t   geom;
    record_t rec;

    cwcg_regs #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cwcg_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .draw_x      (s_tdata[15:0]),
        .draw_y      (s_tdata[31:16]),
        .draw_width  (s_tdata[46:32]),
        .draw_height (s_tdata[61:47]),
        .row_stride  (s_tdata[77:62]),
        .out_valid   (geom_valid),
        .out_ready   (geom_ready),
        .out_geom    (geom)
    );

    cwcg_math u_math (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (geom_valid),
        .in_ready  (geom_ready),
        .in_geom   (geom),
        .out_valid (rec_valid),
        .out_ready (rec_ready),
        .out_rec   (rec)
    );

    cwcg_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rec_valid),
        .in_ready (rec_ready),
        .in_rec   (rec),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/cwcg_checker.sv */
// Port-level checker for the clipped window command generator output channel.
// Depends on cwcg_pkg and clipped_window_command_gen_macros.svh; bound below.
`include "clipped_window_command_gen_macros.svh"

module cwcg_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cwcg_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);
    import cwcg_pkg::*;

    `CWCG_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output word changed under stall")

    `CWCG_ASSERT_IMP(a_empty_word, m_tvalid && !m_tdata[0], m_tlast && !m_tuser && (m_tdata[63:1] == '0), "empty request word not single and clean")

    `CWCG_ASSERT_IMP(a_mid_word, m_tvalid && !m_tlast, m_tdata[0] && (m_tdata[63:9] == '0), "totals present before the closing word")

    `CWCG_ASSERT_IMP(a_cmd_byte, m_tvalid && m_tuser, m_tdata[0] && ((m_tdata[8:1] == CMD_COLUMN) || (m_tdata[8:1] == CMD_ROW) || (m_tdata[8:1] == CMD_WRITE)), "command flag on a non-command byte")

    `CWCG_ASSERT_IMP(a_close_word, m_tvalid && m_tlast && m_tdata[0], m_tuser && (m_tdata[8:1] == CMD_WRITE), "visible request does not close with write command")

endmodule

bind clipped_window_command_gen cwcg_checker u_checker (.*);
